// File: rtl/core/text_to_signed_integer_parser_defines.svh
// Assertion macros for the text to signed integer parser.
`ifndef TEXT_TO_SIGNED_INTEGER_PARSER_DEFINES_SVH
`define TEXT_TO_SIGNED_INTEGER_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TTSI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define TTSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ttsi_pkg.sv
// Types, constants and character helpers shared by the parser files.
`default_nettype none

package ttsi_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned BASE_W     = 6;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned END_W      = 12;
  localparam int unsigned PROD_W     = VALUE_W + BASE_W;
  localparam int unsigned MAX_POSITION_DEF = 4095;

  localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] NEG_LIMIT = 32'h8000_0000;

  localparam logic [CH_W-1:0] CHAR_UPPER_OFFSET = 8'd55;  // 'A' - 10
  localparam logic [CH_W-1:0] CHAR_LOWER_OFFSET = 8'd87;  // 'a' - 10
  localparam logic [CH_W-1:0] NOT_A_DIGIT       = 8'hff;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_BIN  = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_FIRST,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    DS_NONE,
    DS_SOME,
    DS_OVER
  } digit_status_t;

  typedef struct packed {
    phase_t             phase;
    logic               negative;
    logic [VALUE_W-1:0] magnitude;
    digit_status_t      digit_status;
    logic [BASE_W-1:0]  active_base;
  } parse_state_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      overflow;
    logic                      converted;
    logic [END_W-1:0]          end_index;
  } parse_result_t;

  localparam parse_state_t ST_RESET = '{
    phase:        PH_SKIP,
    negative:     1'b0,
    magnitude:    '0,
    digit_status: DS_NONE,
    active_base:  BASE_AUTO
  };

  function automatic logic is_blank(input logic [CH_W-1:0] c);
    return c inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
  endfunction

  // Digit weight 0..35, or NOT_A_DIGIT.
  function automatic logic [CH_W-1:0] digit_of(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] d;
    if (c >= "0" && c <= "9") begin
      d = c - 8'h30;
    end else if (c >= "A" && c <= "Z") begin
      d = c - CHAR_UPPER_OFFSET;
    end else if (c >= "a" && c <= "z") begin
      d = c - CHAR_LOWER_OFFSET;
    end else begin
      d = NOT_A_DIGIT;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ttsi_in_if.sv
// Character channel: valid/ready plus one character.
`default_nettype none

interface ttsi_in_if;
  import ttsi_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ttsi_out_if.sv
// Result channel: valid/ready plus the parsed value and its flags.
`default_nettype none

interface ttsi_out_if;
  import ttsi_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      overflow;
  logic                      converted;
  logic [END_W-1:0]          end_index;

  modport source (output valid, output value, output overflow, output converted,
                  output end_index, input ready);
  modport sink   (input valid, input value, input overflow, input converted,
                  input end_index, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ttsi_step.sv
// Next-state and result logic for one character.
`default_nettype none

module ttsi_step #(
  parameter int unsigned MAX_POSITION = ttsi_pkg::MAX_POSITION_DEF,
  parameter int unsigned POS_W        = $clog2(MAX_POSITION + 1)
) (
  input  ttsi_pkg::parse_state_t          st,
  input  logic [POS_W-1:0]                position,
  input  logic [ttsi_pkg::CH_W-1:0]       ch,
  input  logic [ttsi_pkg::BASE_W-1:0]     number_base,
  output ttsi_pkg::parse_state_t          st_next,
  output logic [POS_W-1:0]                pos_next,
  output logic                            res_valid,
  output ttsi_pkg::parse_result_t         res
);
  import ttsi_pkg::*;

  logic [CH_W-1:0]    d;
  logic               nb_auto;
  logic               nb_hex;
  logic               nb_bin;
  logic               start_first;
  logic               use_digit;
  logic [BASE_W-1:0]  base;
  digit_status_t      dstat;
  logic [VALUE_W-1:0] mag;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  limit;

  assign d       = digit_of(ch);
  assign nb_auto = (number_base == BASE_AUTO);
  assign nb_hex  = (number_base == BASE_HEX);
  assign nb_bin  = (number_base == BASE_BIN);

  always_comb begin
    st_next     = st;
    pos_next    = (position != POS_W'(MAX_POSITION)) ? position + 1'b1 : position;
    res_valid   = 1'b0;
    res         = '0;
    start_first = 1'b0;
    use_digit   = 1'b0;
    base        = st.active_base;
    dstat       = st.digit_status;
    mag         = st.magnitude;

    unique case (st.phase)
      PH_SKIP: begin
        if (is_blank(ch)) begin
          st_next.phase = PH_SKIP;
        end else if (ch == "-") begin
          st_next.negative = 1'b1;
          st_next.phase    = PH_FIRST;
        end else if (ch == "+") begin
          st_next.phase = PH_FIRST;
        end else begin
          start_first = 1'b1;
        end
      end
      PH_FIRST: start_first = 1'b1;
      PH_ZERO: begin
        if ((nb_auto || nb_hex) && (ch == "x" || ch == "X")) begin
          st_next.active_base = BASE_HEX;
          st_next.phase       = PH_DIGITS;
        end else if ((nb_auto || nb_bin) && (ch == "b" || ch == "B")) begin
          st_next.active_base = BASE_BIN;
          st_next.phase       = PH_DIGITS;
        end else begin
          // the leading zero counts as a converted digit
          base      = nb_auto ? BASE_OCT : number_base;
          dstat     = DS_SOME;
          mag       = '0;
          use_digit = 1'b1;
        end
      end
      PH_DIGITS: use_digit = 1'b1;
    endcase

    if (start_first) begin
      if (ch == "0" && (nb_auto || nb_hex || nb_bin)) begin
        st_next.phase = PH_ZERO;
      end else begin
        base      = nb_auto ? BASE_DEC : number_base;
        use_digit = 1'b1;
      end
    end

    prod  = PROD_W'(mag) * PROD_W'(base) + PROD_W'(d);
    limit = st.negative ? PROD_W'(NEG_LIMIT) : PROD_W'(POS_LIMIT);

    if (use_digit) begin
      st_next.phase        = PH_DIGITS;
      st_next.active_base  = base;
      st_next.digit_status = dstat;
      st_next.magnitude    = mag;
      if (d < CH_W'(base)) begin
        if (dstat != DS_OVER) begin
          if (prod > limit) begin
            st_next.digit_status = DS_OVER;
          end else begin
            st_next.magnitude    = prod[VALUE_W-1:0];
            st_next.digit_status = DS_SOME;
          end
        end
      end else begin
        res_valid = 1'b1;
        if (dstat == DS_OVER) begin
          res.value     = st.negative ? NEG_LIMIT : POS_LIMIT;
          res.overflow  = 1'b1;
          res.converted = 1'b1;
        end else begin
          res.value     = st.negative ? (VALUE_W'(0) - mag) : mag;
          res.converted = (dstat == DS_SOME);
        end
        res.end_index = res.converted ? END_W'(position) : '0;
        st_next       = ST_RESET;
        pos_next      = '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/text_to_signed_integer_parser.sv
// Streaming text to signed 32-bit integer parser, top level.
//
//   channel   dir   payload                                     role
//   chars     in    ch[7:0]                                     one character per word
//   results   out   value[31:0], overflow, converted, end_index one word per number
//   cfg       in    cfg_wr_en, cfg_wr_data[5:0]                 number_base register
//
// One character per cycle unless a held result stalls; a terminating character
// passes the input register, then parse logic into the result register.
// The per-digit multiply-add and limit compare set the cycle time.
// rst clears parser state, position, number_base and both valid flags.
// A held result stalls the input register, and chars.ready drops the same cycle.
`default_nettype none

`include "text_to_signed_integer_parser_defines.svh"

module text_to_signed_integer_parser #(
  parameter int unsigned MAX_POSITION = ttsi_pkg::MAX_POSITION_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  ttsi_in_if.sink                     chars,
  ttsi_out_if.source                  results,
  input  logic                        cfg_wr_en,
  input  logic [ttsi_pkg::BASE_W-1:0] cfg_wr_data
);
  import ttsi_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_POSITION + 1);

  logic [BASE_W-1:0] number_base;
  logic              s1_valid;
  logic [CH_W-1:0]   s1_ch;
  logic              s1_fire;
  parse_state_t      st;
  parse_state_t      st_next;
  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  pos_next;
  logic              step_res_valid;
  parse_result_t     step_res;
  logic              out_valid;
  parse_result_t     out_res;

  assign s1_fire     = s1_valid && (!out_valid || results.ready);
  assign chars.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_AUTO;
    end else if (cfg_wr_en) begin
      number_base <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_ch <= chars.ch;
    end
  end

  ttsi_step #(
    .MAX_POSITION (MAX_POSITION),
    .POS_W        (POS_W)
  ) u_step (
    .st          (st),
    .position    (position),
    .ch          (s1_ch),
    .number_base (number_base),
    .st_next     (st_next),
    .pos_next    (pos_next),
    .res_valid   (step_res_valid),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_RESET;
      position <= '0;
    end else if (s1_fire) begin
      st       <= st_next;
      position <= pos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && step_res_valid) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && step_res_valid) begin
      out_res <= step_res;
    end
  end

  assign results.valid     = out_valid;
  assign results.value     = out_res.value;
  assign results.overflow  = out_res.overflow;
  assign results.converted = out_res.converted;
  assign results.end_index = out_res.end_index;

  `TTSI_ASSERT_NOW(a_ovf_implies_conv, results.valid && results.overflow, results.converted, "overflow without converted digits")
  `TTSI_ASSERT_NOW(a_empty_is_zero, results.valid && !results.converted, results.value == '0 && results.end_index == '0, "empty result carries data")
  `TTSI_ASSERT_NEXT(a_restart_after_word, s1_fire && step_res_valid, st.phase == PH_SKIP && position == '0, "parser not restarted after result")
  `TTSI_ASSERT_NOW(a_over_only_in_digits, st.digit_status == DS_OVER, st.phase == PH_DIGITS, "overflow status outside digit phase")

endmodule

`default_nettype wire
